### rtl/ipa_pkg.sv
package ipa_pkg;

    // Format codes on the command field
    localparam logic [1:0] CMD_UDEC = 2'd0;
    localparam logic [1:0] CMD_SDEC = 2'd1;
    localparam logic [1:0] CMD_HEX  = 2'd2;
    localparam logic [1:0] CMD_BIN  = 2'd3;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    localparam int unsigned DIGIT_DEPTH = 32;
    localparam int unsigned COUNT_BITS  = 6;
    localparam int unsigned VALUE_BITS  = 32;
    localparam int unsigned DEC_SHIFT   = 35;
    // floor(v / 10) == (v * DEC_RECIP) >> DEC_SHIFT for every 32-bit v
    localparam logic [31:0] DEC_RECIP   = 32'hCCCC_CCCD;
    localparam logic [3:0]  DEC_BASE    = 4'd10;

    typedef struct packed {
        logic load;
        logic mul;
        logic rem;
        logic shift;
        logic setup;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_decimal;
        logic dec_done;
        logic shift_done;
        logic out_free;
        logic emit_last;
    } t_dp_status;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < DEC_BASE) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_UPPER_A + {4'd0, d - DEC_BASE};
        end
        return c;
    endfunction

endpackage

### rtl/ipa_ctrl.sv
module ipa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ipa_pkg::t_dp_status i_status,
    output ipa_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_REM,
        S_SHIFT,
        S_SETUP,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.in_decimal ? S_MUL : S_SHIFT;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_REM;
            end
            S_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = i_status.dec_done ? S_SETUP : S_MUL;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = i_status.shift_done ? S_SETUP : S_SHIFT;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                // advance only when the output register can take a word
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

### rtl/ipa_datapath.sv
module ipa_datapath #(
    parameter int unsigned MAX_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_command,
    input  logic                i_wide,
    input  logic [31:0]         i_value,
    input  logic [5:0]          i_width,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [7:0]          o_char_code,
    output logic                o_last,
    input  ipa_pkg::t_dp_cmd    i_cmd,
    output ipa_pkg::t_dp_status o_status
);

    localparam int unsigned W_BITS = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CW = (W_BITS > ipa_pkg::COUNT_BITS) ? W_BITS : ipa_pkg::COUNT_BITS;
    localparam int unsigned STACK_BITS = ipa_pkg::DIGIT_DEPTH * 4;

    logic [31:0]                     r_value;
    logic [31:0]                     r_quot;
    logic [STACK_BITS-1:0]           r_stack;
    logic [ipa_pkg::COUNT_BITS-1:0]  r_count;
    logic                            r_neg;
    logic                            r_hex;
    logic [7:0]                      r_pad_char;
    logic [CW-1:0]                   r_weff;
    logic [CW-1:0]                   r_pad;
    logic                            r_out_valid;
    logic [7:0]                      r_char;
    logic                            r_last;

    logic [31:0]  in_v;
    logic [15:0]  mag16;
    logic         in_neg;
    logic [31:0]  in_mag;
    logic [CW-1:0] in_w;
    logic [63:0]  prod;
    logic [31:0]  quot;
    logic [31:0]  rem32;
    logic [3:0]   dec_digit;
    logic [31:0]  shifted;
    logic [3:0]   shift_digit;
    logic [CW-1:0] need;
    logic         emit_last;
    logic         out_free;

    // operand select and sign handling at load
    always_comb begin
        in_v   = i_wide ? i_value : {16'd0, i_value[15:0]};
        mag16  = 16'(16'd0 - i_value[15:0]);
        in_neg = (i_command == ipa_pkg::CMD_SDEC) &&
                 (i_wide ? i_value[31] : i_value[15]);
        if (!in_neg) begin
            in_mag = in_v;
        end else if (i_wide) begin
            in_mag = 32'(32'd0 - i_value);
        end else begin
            in_mag = {16'd0, mag16};
        end
        if (i_width == 6'd0) begin
            in_w = CW'(1);
        end else if (CW'(i_width) > CW'(MAX_WIDTH)) begin
            in_w = CW'(MAX_WIDTH);
        end else begin
            in_w = CW'(i_width);
        end
    end

    always_comb begin
        prod      = 64'(r_value) * 64'(ipa_pkg::DEC_RECIP);
        quot      = 32'(prod[63:ipa_pkg::DEC_SHIFT]);
        rem32     = r_value - ((r_quot << 3) + (r_quot << 1));
        dec_digit = rem32[3:0];
        if (r_hex) begin
            shifted     = r_value >> 4;
            shift_digit = r_value[3:0];
        end else begin
            shifted     = r_value >> 1;
            shift_digit = {3'd0, r_value[0]};
        end
        need      = CW'(r_count) + CW'(r_neg);
        emit_last = (r_pad == '0) && !r_neg &&
                    (r_count == ipa_pkg::COUNT_BITS'(1));
        out_free  = !r_out_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value    <= in_mag;
            r_neg      <= in_neg;
            r_hex      <= (i_command == ipa_pkg::CMD_HEX);
            r_pad_char <= i_command[1] ? ipa_pkg::CHAR_ZERO : ipa_pkg::CHAR_SPACE;
            r_weff     <= in_w;
            r_count    <= '0;
            r_pad      <= '0;
        end
        if (i_cmd.mul) begin
            r_quot <= quot;
        end
        if (i_cmd.rem) begin
            r_stack <= {r_stack[STACK_BITS-5:0], dec_digit};
            r_value <= r_quot;
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.shift) begin
            r_stack <= {r_stack[STACK_BITS-5:0], shift_digit};
            r_value <= shifted;
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.setup) begin
            r_pad <= (r_weff > need) ? CW'(r_weff - need) : '0;
        end
        if (i_cmd.emit) begin
            r_last <= emit_last;
            if (r_pad != '0) begin
                r_char <= r_pad_char;
                r_pad  <= r_pad - 1'b1;
            end else if (r_neg) begin
                r_char <= ipa_pkg::CHAR_MINUS;
                r_neg  <= 1'b0;
            end else begin
                // pop the most significant digit left on the stack
                r_char  <= ipa_pkg::digit_char(r_stack[3:0]);
                r_stack <= {4'd0, r_stack[STACK_BITS-1:4]};
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.in_decimal = !i_command[1];
    assign o_status.dec_done   = (r_quot == '0);
    assign o_status.shift_done = (shifted == '0);
    assign o_status.out_free   = out_free;
    assign o_status.emit_last  = emit_last;

    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rem || i_cmd.shift) |->
            (r_count < ipa_pkg::COUNT_BITS'(ipa_pkg::DIGIT_DEPTH)))
        else $error("digit stack overfilled");

    a_dec_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rem |-> (dec_digit < ipa_pkg::DEC_BASE))
        else $error("decimal remainder out of range");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && emit_last) |=> (r_count == '0) && o_last && o_valid)
        else $error("final character left digits behind");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("character emitted over a waiting word");

endmodule

### rtl/integer_to_padded_ascii_unit.sv
// Sequence: load, then MUL (reciprocal multiplier) and REM steps per decimal
// digit or a shift step per hex/binary digit, then a setup step, then one
// character per cycle through the output register while the sink takes
// them. One number at a time; the next is taken once its final character
// is in the output register. Reset: synchronous, active low, returns the
// sequencer to idle and empties the output register.
module integer_to_padded_ascii_unit #(
    parameter int unsigned MAX_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic        i_wide,
    input  logic [31:0] i_value,
    input  logic [5:0]  i_width,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_char_code,
    output logic        o_last
);

    ipa_pkg::t_dp_cmd    cmd;
    ipa_pkg::t_dp_status status;

    ipa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ipa_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_command   (i_command),
        .i_wide      (i_wide),
        .i_value     (i_value),
        .i_width     (i_width),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule
